### sv/ecal_pkg.sv
package ecal_pkg;

    localparam int StepW = 4;
    localparam int AccW = 32;
    localparam int ProdW = 64;
    localparam int RemW = 6;
    localparam int DaysW = 16;
    localparam int YearW = 12;
    localparam int MonthW = 4;
    localparam int OutW = 38;
    localparam int OutBytesW = 40;

    localparam logic [YearW-1:0] BaseYear = 12'd1970;
    localparam logic [DaysW-1:0] QuadDays = 16'd1461;
    localparam logic [DaysW-1:0] LeapDays = 16'd366;
    localparam logic [DaysW-1:0] PlainDays = 16'd365;

    // exact for every 32-bit dividend
    localparam logic [AccW-1:0] Recip60 = 32'h88888889;
    localparam logic [AccW-1:0] Recip24 = 32'hAAAAAAAB;
    localparam int Shift60 = 37;
    localparam int Shift24 = 36;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_SAVE_SEC,
        OP_SAVE_MIN,
        OP_SAVE_HOUR,
        OP_QUAD,
        OP_YEAR,
        OP_MONTH,
        OP_PUBLISH
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_QUAD,
        C_YEAR,
        C_MONTH,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [StepW-1:0] target;
        logic             div_by60;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic quad_more;
        logic year_more;
        logic month_more;
        logic out_blocked;
    } status_t;

    localparam logic [StepW-1:0] StepWait = 4'd0;
    localparam logic [StepW-1:0] StepQuad = 4'd7;
    localparam logic [StepW-1:0] StepYear = 4'd8;
    localparam logic [StepW-1:0] StepMonth = 4'd9;
    localparam logic [StepW-1:0] StepPublish = 4'd10;
    localparam logic [StepW-1:0] StepLast = 4'd11;

    function automatic ctrl_t ucode_rom(input logic [StepW-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: StepWait, div_by60: 1'b0};
        unique case (pc)
            4'd0:  w = '{OP_LOAD,      C_NO_INPUT,    StepWait,    1'b0};
            4'd1:  w = '{OP_DIV,       C_NEXT,        StepWait,    1'b1};
            4'd2:  w = '{OP_SAVE_SEC,  C_NEXT,        StepWait,    1'b0};
            4'd3:  w = '{OP_DIV,       C_NEXT,        StepWait,    1'b1};
            4'd4:  w = '{OP_SAVE_MIN,  C_NEXT,        StepWait,    1'b0};
            4'd5:  w = '{OP_DIV,       C_NEXT,        StepWait,    1'b0};
            4'd6:  w = '{OP_SAVE_HOUR, C_NEXT,        StepWait,    1'b0};
            4'd7:  w = '{OP_QUAD,      C_QUAD,        StepQuad,    1'b0};
            4'd8:  w = '{OP_YEAR,      C_YEAR,        StepYear,    1'b0};
            4'd9:  w = '{OP_MONTH,     C_MONTH,       StepMonth,   1'b0};
            4'd10: w = '{OP_PUBLISH,   C_OUT_BLOCKED, StepPublish, 1'b0};
            4'd11: w = '{OP_NOP,       C_ALWAYS,      StepWait,    1'b0};
            default: w = '{OP_NOP,     C_ALWAYS,      StepWait,    1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [DaysW-1:0] month_days(input logic [MonthW-1:0] m,
                                                    input logic leap);
        logic [DaysW-1:0] d;
        d = 16'd31;
        case (m)
            4'd1: d = leap ? 16'd29 : 16'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 16'd30;
            default: d = 16'd31;
        endcase
        return d;
    endfunction

endpackage

### sv/ecal_seq.sv
module ecal_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  ecal_pkg::status_t status,
    output ecal_pkg::ctrl_t   ctrl
);
    import ecal_pkg::*;

    logic [StepW-1:0] pc_reg;
    logic [StepW-1:0] pc_next;
    logic             take;

    assign ctrl = ucode_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_INPUT:    take = !status.in_valid;
            C_QUAD:        take = status.quad_more;
            C_YEAR:        take = status.year_more;
            C_MONTH:       take = status.month_more;
            C_OUT_BLOCKED: take = status.out_blocked;
            default:       take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= StepWait;
        end else begin
            pc_reg <= pc_next;
        end
    end

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= StepLast) else $error("step counter out of program");
    a_wait_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_LOAD && !status.in_valid) |=> pc_reg == StepWait)
        else $error("left wait step without a word");
    a_publish_stay: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_PUBLISH && status.out_blocked) |=> pc_reg == StepPublish)
        else $error("left publish step while output busy");

endmodule

### sv/ecal_dp.sv
module ecal_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ecal_pkg::ctrl_t                ctrl,
    output ecal_pkg::status_t              status,
    input  logic                           s_tvalid,
    input  logic [ecal_pkg::AccW-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ecal_pkg::OutBytesW-1:0] m_tdata
);
    import ecal_pkg::*;

    logic [AccW-1:0]   acc_reg, acc_next;
    logic [AccW-1:0]   quo_reg, quo_next;
    logic [RemW-1:0]   sec_reg, sec_next;
    logic [RemW-1:0]   min_reg, min_next;
    logic [4:0]        hour_reg, hour_next;
    logic [DaysW-1:0]  days_reg, days_next;
    logic [YearW-1:0]  year_reg, year_next;
    logic [MonthW-1:0] month_reg, month_next;
    logic [OutW-1:0]   out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [AccW-1:0]   recip;
    logic [ProdW-1:0]  prod;
    logic [AccW-1:0]   quo;
    logic              leap;
    logic [DaysW-1:0]  ylen;
    logic [DaysW-1:0]  mlen;
    logic [4:0]        day_out;

    // quotient by reciprocal multiplication
    assign recip = ctrl.div_by60 ? Recip60 : Recip24;
    assign prod = ProdW'(acc_reg) * ProdW'(recip);
    assign quo = ctrl.div_by60 ? AccW'(prod[ProdW-1:Shift60]) : AccW'(prod[ProdW-1:Shift24]);
    assign leap = year_reg[1:0] == 2'b00;
    assign ylen = leap ? LeapDays : PlainDays;
    assign mlen = month_days(month_reg, leap);
    assign day_out = days_reg[4:0] + 5'd1;

    assign status.in_valid = s_tvalid;
    assign status.quad_more = days_reg >= QuadDays;
    assign status.year_more = days_reg >= ylen;
    assign status.month_more = days_reg >= mlen;
    assign status.out_blocked = m_tvalid_reg && !m_tready;

    always_comb begin
        acc_next = acc_reg;
        quo_next = quo_reg;
        sec_next = sec_reg;
        min_next = min_reg;
        hour_next = hour_reg;
        days_next = days_reg;
        year_next = year_reg;
        month_next = month_reg;
        out_next = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (ctrl.op)
            OP_LOAD: begin
                acc_next = s_tdata;
            end
            OP_DIV: begin
                quo_next = quo;
            end
            OP_SAVE_SEC: begin
                // t - 60q taken mod 64
                sec_next = acc_reg[RemW-1:0] + {quo_reg[3:0], 2'b00};
                acc_next = quo_reg;
            end
            OP_SAVE_MIN: begin
                min_next = acc_reg[RemW-1:0] + {quo_reg[3:0], 2'b00};
                acc_next = quo_reg;
            end
            OP_SAVE_HOUR: begin
                // t - 24q taken mod 32
                hour_next = acc_reg[4:0] + {quo_reg[1:0], 3'b000};
                days_next = quo_reg[DaysW-1:0];
                year_next = BaseYear;
                month_next = '0;
            end
            OP_QUAD: begin
                if (status.quad_more) begin
                    days_next = days_reg - QuadDays;
                    year_next = year_reg + 12'd4;
                end
            end
            OP_YEAR: begin
                if (status.year_more) begin
                    days_next = days_reg - ylen;
                    year_next = year_reg + 12'd1;
                end
            end
            OP_MONTH: begin
                if (status.month_more) begin
                    days_next = days_reg - mlen;
                    month_next = month_reg + 4'd1;
                end
            end
            OP_PUBLISH: begin
                if (!status.out_blocked) begin
                    out_next = {sec_reg, min_reg, hour_reg, day_out,
                                month_reg + 4'd1, year_reg};
                    m_tvalid_next = 1'b1;
                end
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        sec_reg <= sec_next;
        min_reg <= min_next;
        hour_reg <= hour_next;
        days_reg <= days_next;
        year_reg <= year_next;
        month_reg <= month_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {{(OutBytesW - OutW){1'b0}}, out_reg};

    a_days_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_SAVE_HOUR |-> quo_reg[AccW-1:DaysW] == '0)
        else $error("day count overflow");
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_MONTH |-> month_reg < 4'd12)
        else $error("month walk past december");
    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_PUBLISH && !status.out_blocked) |=> m_tvalid_reg)
        else $error("result not presented");

endmodule

### sv/epoch_seconds_to_calendar_unit.sv
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute and second; every year divisible by 4 is leap,
// so 2100 is leap. A word goes from acceptance to result through
// six steps for the divisions by 60, 60 and 24 (one reciprocal multiply and
// one remainder step each), a walk of up to 34 four-year steps and one of up
// to three single years, each with one more step to leave it, a month walk of
// up to 11 steps plus one to leave, and one publish step. The microcode
// sequencer then spends one more step before the wait step, so the next word is
// taken only after the last has left publish. One word is in work at a time;
// s_tready is high only in the wait step, and the publish step holds while the
// previous result still sits unaccepted in the output register.
module epoch_seconds_to_calendar_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second
);
    import ecal_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    ecal_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    ecal_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = ctrl.op == OP_LOAD;

endmodule

### verif/epoch_seconds_to_calendar_unit_test.sv
module epoch_seconds_to_calendar_unit_test;

    import ecal_pkg::*;

    localparam int RandomWords = 1330;
    localparam int CalmWords = 120;
    localparam int LongHoldAt = 250;
    localparam int DrainAt = 700;
    localparam int LongHold = 600;
    localparam int QuietLimit = 4000;
    localparam int SettleCycles = 300;

    // packed so that year sits in the low bits, as on m_tdata
    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } cal_t;

    typedef struct packed {
        logic [31:0] secs;
        logic        typed;
        cal_t        cal;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // epoch_seconds
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second

    cal_t expected_dates[$];
    int   mismatches = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;
    bit   long_hold_pending = 1'b0;
    bit   long_hold_done = 1'b0;
    int   hold_left = 0;

    row_t directed_rows [18] = '{
        '{32'd0,          1'b1, '{year: 12'd1970, month: 4'd1, day: 5'd1,
                                  hour: 5'd0, minute: 6'd0, second: 6'd0}},
        '{32'd59,         1'b1, '{year: 12'd1970, month: 4'd1, day: 5'd1,
                                  hour: 5'd0, minute: 6'd0, second: 6'd59}},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd3600,       1'b0, '0},
        '{32'd86399,      1'b1, '{year: 12'd1970, month: 4'd1, day: 5'd1,
                                  hour: 5'd23, minute: 6'd59, second: 6'd59}},
        '{32'd86400,      1'b1, '{year: 12'd1970, month: 4'd1, day: 5'd2,
                                  hour: 5'd0, minute: 6'd0, second: 6'd0}},
        '{32'd2678400,    1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd4102444800, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4107628800, 1'b0, '0},
        '{32'h7FFFFFFF,   1'b0, '0},
        '{32'h80000000,   1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'hFFFFFFFF,   1'b1, '{year: 12'd2106, month: 4'd2, day: 5'd6,
                                  hour: 5'd6, minute: 6'd28, second: 6'd15}}
    };

    epoch_seconds_to_calendar_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // every year divisible by 4 is leap, 2100 included
    function automatic cal_t calendar_of(input logic [31:0] secs);
        int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned ylen;
        int unsigned mlen;
        cal_t c;
        t = secs;
        c.second = 6'(t % 60);
        t = t / 60;
        c.minute = 6'(t % 60);
        t = t / 60;
        c.hour = 5'(t % 24);
        days = t / 24;
        yr = 1970;
        forever begin
            ylen = (yr % 4 == 0) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            yr++;
        end
        for (mon = 0; mon < 12; mon++) begin
            mlen = (mon == 1) ? ((yr % 4 == 0) ? 29 : 28) : month_len[mon];
            if (days < mlen) break;
            days -= mlen;
        end
        c.year = 12'(yr);
        c.month = 4'(mon + 1);
        c.day = 5'(days + 1);
        return c;
    endfunction

    task automatic offer(input logic [31:0] secs, input logic typed, input cal_t typed_cal);
        s_tdata <= secs;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_dates.push_back(typed ? typed_cal : calendar_of(secs));
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // receiver side: short random stalls, one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (long_hold_pending && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= LongHold - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cal_t want;
        cal_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[37:0];
            if (expected_dates.size() == 0) begin
                $error("word out with nothing pending: %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_dates.pop_front();
                check_field("cal_year", 32'(want.year), 32'(got.year));
                check_field("cal_month", 32'(want.month), 32'(got.month));
                check_field("cal_day", 32'(want.day), 32'(got.day));
                check_field("cal_hour", 32'(want.hour), 32'(got.hour));
                check_field("cal_minute", 32'(want.minute), 32'(got.minute));
                check_field("cal_second", 32'(want.second), 32'(got.second));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [31:0] secs;
        int unsigned day_no;
        int unsigned yr;
        int unsigned pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].cal);
        end

        for (int n = 0; n < RandomWords; n++) begin
            calm = (n >= RandomWords - CalmWords);
            if (n == LongHoldAt) long_hold_pending = 1'b1;
            if (n == DrainAt) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_dates.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                secs = $urandom();
            end else if (pick <= 7) begin
                // around midnight of a random day
                day_no = $urandom_range(0, 49710);
                secs = day_no * 86400 + ($urandom_range(0, 1) ? 86399 - $urandom_range(0, 2)
                                                              : $urandom_range(0, 2));
            end else if (pick == 8) begin
                // around new year
                yr = 1970 + $urandom_range(0, 136);
                day_no = (yr - 1970) * 365 + (yr - 1969) / 4;
                secs = day_no * 86400 + $urandom_range(0, 2) - $urandom_range(0, 2);
            end else begin
                secs = $urandom_range(0, 100000000);
            end
            offer(secs, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
sv/ecal_pkg.sv
sv/ecal_seq.sv
sv/ecal_dp.sv
sv/epoch_seconds_to_calendar_unit.sv
verif/epoch_seconds_to_calendar_unit_test.sv
